// ===== src/tte_pkg.sv =====
`timescale 1ns / 1ps

package tte_pkg;

    // Window geometry
    localparam int WINDOW_DEPTH = 8;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int COUNT_W      = $clog2(WINDOW_DEPTH + 1);

    // Field widths
    localparam int TIME_W  = 32;
    localparam int IV_W    = 16;
    localparam int TEMPO_W = 16;
    localparam int FILL_W  = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam int IV_MAX  = (1 << IV_W) - 1;
    localparam int SUM_W   = $clog2(IV_MAX * WINDOW_DEPTH + 1);

    // Tempo = floor((2 * 60000 * count + sum) / (2 * sum)), saturated
    localparam int TEMPO_NUM    = 60000;
    localparam int TWICE_NUM    = 2 * TEMPO_NUM;
    localparam int NUM_W        = $clog2((TWICE_NUM + IV_MAX) * WINDOW_DEPTH + 1);
    localparam int DEN_W        = SUM_W + 1;
    localparam int DIV_CNT_W    = $clog2(NUM_W + 1);

    localparam logic [TEMPO_W-1:0] TEMPO_CEIL = TEMPO_W'(60000);

    // Register map
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_IDX = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDX = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     MIN_RESET   = CFG_W'(200);
    localparam logic [CFG_W-1:0]     MAX_RESET   = CFG_W'(3000);

    // Output beat layout
    localparam int TDATA_W = 24;
    localparam int TUSER_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PUSH,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic read;
        logic push;
    } t_win_cmd;

endpackage

// ===== src/tte_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tte_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tte_pkg::NUM_W-1:0]  i_num,
    input  logic [tte_pkg::DEN_W-1:0]  i_den,
    output logic                       o_done,
    output logic [tte_pkg::NUM_W-1:0]  o_quo
);
    import tte_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;
    logic [NUM_W-1:0]     r_quo;

    logic [DEN_W:0]       w_shift;
    logic [DEN_W:0]       w_diff;
    logic                 w_ge;

    assign w_shift = {r_rem, r_quo[NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_ge    = ~w_diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_shift[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== src/tte_win.sv =====
`timescale 1ns / 1ps

// Interval window: ring of the last intervals with running count and sum.
module tte_win (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tte_pkg::t_win_cmd           i_cmd,
    input  logic [tte_pkg::IV_W-1:0]    i_interval,
    output logic [tte_pkg::COUNT_W-1:0] o_count,
    output logic [tte_pkg::SUM_W-1:0]   o_sum
);
    import tte_pkg::*;

    logic [IV_W-1:0]    r_mem [WINDOW_DEPTH];
    logic [IV_W-1:0]    r_rd;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_count;
    logic [SUM_W-1:0]   r_sum;

    logic               w_full;
    logic [SUM_W-1:0]   w_evict;
    logic [SLOT_W-1:0]  w_slot_nxt;

    assign w_full     = (r_count == COUNT_W'(WINDOW_DEPTH));
    assign w_evict    = w_full ? SUM_W'(r_rd) : '0;
    assign w_slot_nxt = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.clear) begin
            r_slot  <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.push) begin
            r_slot  <= w_slot_nxt;
            r_sum   <= r_sum + SUM_W'(i_interval) - w_evict;
            if (!w_full) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Read the entry about to be overwritten in the cycle before the push
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_slot] <= i_interval;
        end
        if (i_cmd.read) begin
            r_rd <= r_mem[r_slot];
        end
    end

    assign o_count = r_count;
    assign o_sum   = r_sum;

endmodule

// ===== src/tap_tempo_estimator.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Contents (lowest bit up)
// -------   ---  ------------------------------  ------------------------------------------
// tap in    in   s_axis_tvalid/tready/tdata      tdata: tap_time_ms[31:0]
// tempo out out  m_axis_tvalid/tready/tdata/tuser tdata: tempo_bpm[15:0], window_fill[19:16],
//                                                 zero[23:20]; tuser: tempo_updated, window_cleared
// config    in   i_cfg_we/i_cfg_idx/i_cfg_wdata  idx 0 min_interval_ms, idx 1 max_interval_ms
//
// One tap beat is handled at a time. A first tap or an out-of-range interval goes from the
// check state straight to the output state; an accepted interval passes the push and numerator
// states and, on a nonzero sum, the restoring divider that retires one quotient bit per cycle.
// The tap input is ready again as soon as the result is parked in the output register,
// so a new tap is taken while the previous result waits. A stalled output holds the
// sequencer in its final state. Reset is synchronous, active low, and needs no clearing pass.
module tap_tempo_estimator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tap beat
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tte_pkg::TIME_W-1:0]    s_axis_tdata,   // tap_time_ms
    // result beat
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tte_pkg::TDATA_W-1:0]   m_axis_tdata,   // tempo_bpm, window_fill, pad
    output logic [tte_pkg::TUSER_W-1:0]   m_axis_tuser,   // tempo_updated, window_cleared
    // register writes
    input  logic                          i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tte_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import tte_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [CFG_W-1:0]    r_min;
    logic [CFG_W-1:0]    r_max;

    logic                r_have;       // a reference tap exists
    logic                r_have_cur;   // the tap in flight had a reference
    logic [TIME_W-1:0]   r_prev;
    logic [TIME_W-1:0]   r_interval;
    logic                r_updated;
    logic                r_cleared;
    logic [TEMPO_W-1:0]  r_tempo;

    logic                r_out_valid;
    logic [TDATA_W-1:0]  r_out_data;
    logic [TUSER_W-1:0]  r_out_user;

    t_win_cmd            w_cmd;
    logic                w_div_start;
    logic                w_div_done;
    logic [NUM_W-1:0]    w_quo;
    logic [COUNT_W-1:0]  w_count;
    logic [SUM_W-1:0]    w_sum;
    logic [NUM_W-1:0]    w_num;
    logic [DEN_W-1:0]    w_den;
    logic                w_in_range;
    logic                w_accept;
    logic                w_out_free;
    logic [TEMPO_W-1:0]  w_quo_sat;

    assign w_accept   = s_axis_tvalid & s_axis_tready;
    assign w_out_free = ~r_out_valid | m_axis_tready;
    assign w_in_range = (r_interval >= TIME_W'(r_min)) && (r_interval <= TIME_W'(r_max));
    assign w_num      = NUM_W'(TWICE_NUM) * NUM_W'(w_count) + NUM_W'(w_sum);
    assign w_den      = {w_sum, 1'b0};
    assign w_quo_sat  = (w_quo > NUM_W'(TEMPO_CEIL)) ? TEMPO_CEIL : w_quo[TEMPO_W-1:0];

    tte_win u_win (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_interval (r_interval[IV_W-1:0]),
        .o_count    (w_count),
        .o_sum      (w_sum)
    );

    tte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (r_have_cur && w_in_range) begin
                    n_state = ST_PUSH;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_PUSH: n_state = ST_NUM;
            ST_NUM: begin
                if (w_sum == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_cmd         = '0;
        w_div_start   = 1'b0;
        unique case (r_state)
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_CHECK: begin
                if (r_have_cur) begin
                    w_cmd.read  = w_in_range;
                    w_cmd.clear = ~w_in_range;
                end
            end
            ST_PUSH:  w_cmd.push  = 1'b1;
            ST_NUM:   w_div_start = (w_sum != '0);
            ST_DIV:   ;
            ST_OUT:   ;
            default:  ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_min       <= MIN_RESET;
            r_max       <= MAX_RESET;
            r_have      <= 1'b0;
            r_prev      <= '0;
            r_tempo     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we && i_cfg_idx == CFG_MIN_IDX) begin
                r_min <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == CFG_MAX_IDX) begin
                r_max <= i_cfg_wdata;
            end
            // Every tap becomes the new reference
            if (w_accept) begin
                r_have <= 1'b1;
                r_prev <= s_axis_tdata;
            end
            if (r_state == ST_NUM && w_sum == '0) begin
                r_tempo <= TEMPO_CEIL;
            end else if (r_state == ST_DIV && w_div_done) begin
                r_tempo <= w_quo_sat;
            end
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Per-tap payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_interval <= s_axis_tdata - r_prev;
            r_have_cur <= r_have;
            r_updated  <= 1'b0;
            r_cleared  <= 1'b0;
        end else if (r_state == ST_CHECK && r_have_cur) begin
            r_updated <= w_in_range;
            r_cleared <= ~w_in_range;
        end
        if (r_state == ST_OUT && w_out_free) begin
            r_out_data <= {(TDATA_W - TEMPO_W - FILL_W)'(0), FILL_W'(w_count), r_tempo};
            r_out_user <= {r_cleared, r_updated};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[TEMPO_W+FILL_W-1:TEMPO_W] <= FILL_W'(WINDOW_DEPTH)))
        else $error("window fill above depth");

    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("tempo updated and window cleared together");

    a_one_tap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !s_axis_tready)
        else $error("second tap taken while one is in flight");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside its state");

endmodule

// ===== dv/tempo_window_check.sv =====
`timescale 1ns / 1ps

// Watches the tap, result and register ports of tap_tempo_estimator. It keeps
// its own copy of the interval window and predicts every result beat. Mismatches
// are counted and handed up as o_fail_count.
module tempo_window_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tap_valid,
    input  logic                          i_tap_ready,
    input  logic [tte_pkg::TIME_W-1:0]    i_tap_time,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic [tte_pkg::TDATA_W-1:0]   i_res_data,
    input  logic [tte_pkg::TUSER_W-1:0]   i_res_user,
    input  logic                          i_cfg_we,
    input  logic [tte_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tte_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import tte_pkg::*;

    localparam int UPDATED_BIT = 0;
    localparam int CLEARED_BIT = 1;
    localparam int FILL_LSB    = TEMPO_W;

    typedef struct packed {
        logic [TEMPO_W-1:0] bpm;
        logic               updated;
        logic               cleared;
        logic [FILL_W-1:0]  fill;
    } t_reading;

    logic [CFG_W-1:0]  min_iv;
    logic [CFG_W-1:0]  max_iv;
    bit                have_prev;
    logic [TIME_W-1:0] prev_time;
    logic [IV_W-1:0]   iv_window [WINDOW_DEPTH];
    int unsigned       slot;
    int unsigned       fill_count;
    logic [31:0]       iv_sum;
    logic [TEMPO_W-1:0] bpm_held;
    t_reading          readings_due [$];
    int                fails = 0;

    initial o_fail_count = 0;
    initial o_pending    = 0;

    // round half up of 60000 * n / total, saturated; a zero sum saturates
    function automatic logic [TEMPO_W-1:0] bpm_from_window(input int unsigned n,
                                                          input logic [31:0] total);
        logic [63:0] num;
        logic [63:0] quot;
        if (total == 0)
            return TEMPO_CEIL;
        num  = 64'(TWICE_NUM) * 64'(n) + 64'(total);
        quot = num / (64'(total) * 64'd2);
        if (quot > 64'(TEMPO_CEIL))
            return TEMPO_CEIL;
        return quot[TEMPO_W-1:0];
    endfunction

    task automatic apply_tap(input logic [TIME_W-1:0] now);
        t_reading    r;
        logic [31:0] iv;
        r.updated = 1'b0;
        r.cleared = 1'b0;
        if (have_prev) begin
            iv = now - prev_time;
            if (iv >= 32'(min_iv) && iv <= 32'(max_iv)) begin
                if (fill_count >= WINDOW_DEPTH)
                    iv_sum -= 32'(iv_window[slot]);
                else
                    fill_count++;
                iv_window[slot] = iv[IV_W-1:0];
                iv_sum += iv;
                slot = (slot + 1) % WINDOW_DEPTH;
                bpm_held = bpm_from_window(fill_count, iv_sum);
                r.updated = 1'b1;
            end else begin
                fill_count = 0;
                iv_sum     = 0;
                slot       = 0;
                r.cleared  = 1'b1;
            end
        end
        have_prev = 1'b1;
        prev_time = now;
        r.bpm  = bpm_held;
        r.fill = FILL_W'(fill_count);
        readings_due = {readings_due, r};
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $error("%s: expected %0d, got %0d", field, want, got);
        end
    endtask

    task automatic check_reading();
        t_reading want;
        if (readings_due.size() == 0) begin
            fails++;
            $error("result beat with no tap waiting: tempo_bpm %0d",
                   i_res_data[TEMPO_W-1:0]);
        end else begin
            want = readings_due.pop_front();
            check_field("tempo_bpm", want.bpm, i_res_data[TEMPO_W-1:0]);
            check_field("window_fill", want.fill, i_res_data[FILL_LSB +: FILL_W]);
            check_field("tempo_updated", want.updated, i_res_user[UPDATED_BIT]);
            check_field("window_cleared", want.cleared, i_res_user[CLEARED_BIT]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            min_iv     = MIN_RESET;
            max_iv     = MAX_RESET;
            have_prev  = 1'b0;
            prev_time  = '0;
            slot       = 0;
            fill_count = 0;
            iv_sum     = 0;
            bpm_held   = '0;
            readings_due.delete();
        end else begin
            if (i_res_valid && i_res_ready)
                check_reading();
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_IDX: min_iv = i_cfg_wdata;
                    CFG_MAX_IDX: max_iv = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_tap_valid && i_tap_ready)
                apply_tap(i_tap_time);
        end
        o_pending    <= readings_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== dv/tap_tempo_estimator_tb.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for tap_tempo_estimator. Prediction and comparison live
// in tempo_window_check, which sits beside the block and watches every port.
module tap_tempo_estimator_tb;

    import tte_pkg::*;

    // the two indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    // longest correct quiet stretch is a random tap gap, the divider and a
    // random output stall back to back
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 40;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TIME_W-1:0]    s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;   // tempo_bpm[15:0], window_fill[19:16], pad
    logic [TUSER_W-1:0]   m_axis_tuser;   // tempo_updated[0], window_cleared[1]
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    bit          calm = 1'b0;     // set for the final setting: no idling at all
    logic [31:0] last_tap = '0;
    int          cur_lo;
    int          cur_hi;
    int          taps_sent = 0;
    int          reg_writes = 0;
    int          settings_run = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    tap_tempo_estimator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    tempo_window_check window_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tap_valid  (s_axis_tvalid),
        .i_tap_ready  (s_axis_tready),
        .i_tap_time   (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Result side back-pressure: drop tready for random bursts, raising it again
    // between bursts; hold it high once the final setting runs.
    always @(negedge i_clk) begin
        if (!calm && stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && m_axis_tready && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: count cycles in which no beat and no register write moves.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tap_tempo_estimator regression: fail");
                $finish;
            end
        end
    end

    // Present one tap beat and hold it until accepted. Enter and leave on a
    // falling edge; tvalid stays high on return so back-to-back taps stream.
    task automatic tap_at(input logic [31:0] stamp);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= stamp;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        last_tap = stamp;
        taps_sent++;
    endtask

    task automatic tap_after(input logic [31:0] iv);
        tap_at(last_tap + iv);
    endtask

    // Drop tvalid and wait until every result is out, so registers see an idle block.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One write per cycle; the last write of a group lowers the enable.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int value,
                             input bit last);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= CFG_W'(value);
        @(negedge i_clk);
        if (last)
            i_cfg_we <= 1'b0;
        reg_writes++;
    endtask

    task automatic program_range(input int lo, input int hi);
        settle();
        reg_write(CFG_MIN_IDX, lo, 1'b0);
        reg_write(CFG_MAX_IDX, hi, 1'b1);
        cur_lo = lo;
        cur_hi = hi;
        settings_run++;
    endtask

    // Random taps: runs of 1 to 20 intervals, in range unless the range is empty (so the
    // window fills and wraps), each run broken by one out-of-range interval or a jump.
    task automatic run_random(input int taps);
        int          left;
        int          run_len;
        int          pick;
        logic [31:0] iv;
        left = taps;
        while (left > 0) begin
            run_len = $urandom_range(1, 20);
            for (int k = 0; k < run_len && left > 0; k++) begin
                pick = $urandom_range(0, 7);
                if (cur_lo > cur_hi)
                    iv = $urandom_range(0, 65535);
                else if (pick == 0)
                    iv = cur_lo;
                else if (pick == 1)
                    iv = cur_hi;
                else
                    iv = $urandom_range(cur_hi, cur_lo);
                tap_after(iv);
                left--;
            end
            if (left > 0) begin
                case ($urandom_range(0, 3))
                    0: tap_after(cur_lo > 0 ? $urandom_range(0, cur_lo - 1) : $urandom);
                    1: tap_after(cur_hi + 1 + ($urandom_range(0, 1) ? 0
                                                 : $urandom_range(0, 70000)));
                    2: tap_at($urandom);
                    default: tap_after($urandom);
                endcase
                left--;
            end
        end
    endtask

    initial begin
        int lo;
        int hi;
        cur_lo = MIN_RESET;
        cur_hi = MAX_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset register values: first tap near the top of the
        // timestamp range, then a wrap, both range edges and just outside them.
        tap_at(32'hFFFF_FE00);
        tap_after(3000);
        tap_after(200);
        tap_after(199);
        tap_after(500);
        tap_after(3001);
        // fill the window and evict its oldest entry
        for (int k = 0; k < 9; k++)
            tap_after(500 + 37 * k);
        tap_at(32'hFFFF_FFFF);
        tap_at(32'h0000_0000);

        // Writes past the register map are dropped; then the widest range
        // with a zero minimum: a zero interval saturates the tempo on a zero
        // sum, then a one-millisecond sum pushes the quotient past the ceiling.
        settle();
        reg_write(CFG_SPARE_LO, 16'hFFFF, 1'b0);
        reg_write(CFG_SPARE_HI, 16'h0001, 1'b1);
        program_range(0, 65535);
        tap_after(0);
        tap_after(1);
        tap_after(65535);
        tap_after(65536);

        // Empty range: every tap clears the window.
        program_range(65535, 1);
        tap_after(1);
        tap_after(65535);
        tap_after(0);

        // Single-value range.
        program_range(1, 1);
        tap_after(1);
        tap_after(1);
        tap_after(2);

        // Random part over several settings, extremes among them.
        program_range(MIN_RESET, MAX_RESET);
        run_random(95);
        program_range(1, 65535);
        run_random(95);
        lo = $urandom_range(1, 1000);
        program_range(lo, lo + $urandom_range(0, 4000));
        run_random(95);
        program_range(65535, 65535);
        run_random(60);
        hi = $urandom_range(1, 30000);
        program_range(hi + $urandom_range(1, 30000), hi);
        run_random(30);
        lo = $urandom_range(1, 65535);
        hi = $urandom_range(1, 65535);
        program_range(lo < hi ? lo : hi, lo < hi ? hi : lo);
        run_random(95);

        // Last setting runs with no idling on either side.
        calm = 1'b1;
        program_range($urandom_range(1, 300), $urandom_range(1500, 4000));
        run_random(153);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d taps over %0d register settings (%0d writes), %0d mismatches.",
                 taps_sent, settings_run, reg_writes, fail_count);
        $display("Random taps came as in-range runs with boundary, wrap and jump noise.");
        if (fail_count == 0)
            $display("tap_tempo_estimator regression: pass");
        else
            $display("tap_tempo_estimator regression: fail");
        $finish;
    end

endmodule
